@@ hdl/rgbhsv_pkg.sv @@
package rgbhsv_pkg;

  localparam int unsigned DIV_STEPS  = 9;
  localparam int unsigned NUM_STAGES = DIV_STEPS + 2;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [8:0] hue_deg;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } pix_out_t;

  // which channel is the smallest; picks the hue sector offset
  typedef enum logic [1:0] {
    SEC_RED_LO   = 2'd0,
    SEC_BLUE_LO  = 2'd1,
    SEC_GREEN_LO = 2'd2
  } sector_e;

  typedef struct packed {
    logic              grey;
    sector_e           sector;
    logic [7:0]        hi;
    logic [7:0]        delta;
    logic signed [8:0] diff;
  } sort_t;

  // one long-division lane: partial remainder, dividend bits still to
  // shift in (quotient bits shift in from the bottom), divisor
  typedef struct packed {
    logic [7:0] rem;
    logic [8:0] bits;
    logic [7:0] dsr;
  } div_lane_t;

  typedef struct packed {
    div_lane_t  hue;
    div_lane_t  sat;
    logic [7:0] hi;
  } div_stage_t;

endpackage

@@ hdl/rgb_to_hsv_pixel.sv @@
// RGB to HSV converter, one item per clock.
// Pipeline: 11 register stages (min/max sort, scale, 9 restoring division steps).
// Throughput: one item per cycle; each stage holds only when the stage after it
// is full and stalled, so bubbles close up under a stall.
// Reset clears all valid bits; payload registers are not reset.
module rgb_to_hsv_pixel
  import rgbhsv_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  pix_in_t  pix_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output pix_out_t pix_o
);

  logic [NUM_STAGES:0]   en;
  logic [NUM_STAGES-1:0] vld;
  sort_t                 sort_data;
  div_stage_t            stage_data [NUM_STAGES-1:1];

  // a stage loads when it is empty or its content moves on
  assign en[NUM_STAGES] = !out_stall_i;
  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end

  rgbhsv_sort u_sort (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en[0]),
    .valid_i (in_valid_i),
    .pix_i   (pix_i),
    .valid_o (vld[0]),
    .data_o  (sort_data)
  );

  rgbhsv_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en[1]),
    .valid_i (vld[0]),
    .data_i  (sort_data),
    .valid_o (vld[1]),
    .data_o  (stage_data[1])
  );

  for (genvar k = 2; k < NUM_STAGES; k++) begin : g_div
    rgbhsv_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en[k]),
      .valid_i (vld[k-1]),
      .data_i  (stage_data[k-1]),
      .valid_o (vld[k]),
      .data_o  (stage_data[k])
    );
  end

  assign in_stall_o         = !en[0];
  assign out_valid_o        = vld[NUM_STAGES-1];
  assign pix_o.hue_deg      = stage_data[NUM_STAGES-1].hue.bits;
  assign pix_o.saturation   = stage_data[NUM_STAGES-1].sat.bits[7:0];
  assign pix_o.brightness   = stage_data[NUM_STAGES-1].hi;

endmodule

@@ hdl/rgbhsv_sort.sv @@
module rgbhsv_sort
  import rgbhsv_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  logic    valid_i,
  input  pix_in_t pix_i,
  output logic    valid_o,
  output sort_t   data_o
);

  logic       valid_q;
  sort_t      data_d, data_q;
  logic [7:0] r, g, b, hi, lo;

  always_comb begin
    r  = pix_i.red_in;
    g  = pix_i.green_in;
    b  = pix_i.blue_in;
    hi = (r > g) ? r : g;
    hi = (hi > b) ? hi : b;
    lo = (r < g) ? r : g;
    lo = (lo < b) ? lo : b;
    data_d.hi    = hi;
    data_d.delta = hi - lo;
    data_d.grey  = (hi == lo);
    // ties on the minimum: red first, then blue
    if (r == lo) begin
      data_d.sector = SEC_RED_LO;
      data_d.diff   = $signed({1'b0, g}) - $signed({1'b0, b});
    end else if (b == lo) begin
      data_d.sector = SEC_BLUE_LO;
      data_d.diff   = $signed({1'b0, r}) - $signed({1'b0, g});
    end else begin
      data_d.sector = SEC_GREEN_LO;
      data_d.diff   = $signed({1'b0, b}) - $signed({1'b0, r});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ hdl/rgbhsv_scale.sv @@
module rgbhsv_scale
  import rgbhsv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  sort_t      data_i,
  output logic       valid_o,
  output div_stage_t data_o
);

  logic               valid_q;
  div_stage_t         data_d, data_q;
  logic [10:0]        od;
  logic signed [11:0] num;
  logic [10:0]        num_u;
  logic [16:0]        hue_dvd;
  logic [16:0]        sat_dvd;

  always_comb begin
    case (data_i.sector)
      SEC_RED_LO:   od = {2'b00, data_i.delta, 1'b0} + {3'b000, data_i.delta};
      SEC_BLUE_LO:  od = {3'b000, data_i.delta};
      SEC_GREEN_LO: od = {1'b0, data_i.delta, 2'b00} + {3'b000, data_i.delta};
      default:      od = '0;
    endcase
    // numerator stays in 0 .. 6*delta-1
    num     = $signed({1'b0, od}) - {{3{data_i.diff[8]}}, data_i.diff};
    num_u   = num[10:0];
    hue_dvd = {num_u, 6'b0} - {4'b0000, num_u, 2'b00};
    sat_dvd = {1'b0, data_i.delta, 8'b0} - {9'b0, data_i.delta};

    data_d.hi = data_i.hi;
    if (data_i.grey) begin
      // zero over one gives zero hue and saturation
      data_d.hue = '{rem: 8'd0, bits: 9'd0, dsr: 8'd1};
      data_d.sat = '{rem: 8'd0, bits: 9'd0, dsr: 8'd1};
    end else begin
      data_d.hue = '{rem: hue_dvd[16:9], bits: hue_dvd[8:0], dsr: data_i.delta};
      data_d.sat = '{rem: sat_dvd[16:9], bits: sat_dvd[8:0], dsr: data_i.hi};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ hdl/rgbhsv_div_step.sv @@
module rgbhsv_div_step
  import rgbhsv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  div_stage_t data_i,
  output logic       valid_o,
  output div_stage_t data_o
);

  logic       valid_q;
  div_stage_t data_d, data_q;

  function automatic div_lane_t step(div_lane_t l);
    logic [8:0] t;
    logic [8:0] sub;
    logic       ge;
    div_lane_t  n;
    t      = {l.rem, l.bits[8]};
    sub    = t - {1'b0, l.dsr};
    ge     = (t >= {1'b0, l.dsr});
    n.rem  = ge ? sub[7:0] : t[7:0];
    n.bits = {l.bits[7:0], ge};
    n.dsr  = l.dsr;
    return n;
  endfunction

  always_comb begin
    data_d.hue = step(data_i.hue);
    data_d.sat = step(data_i.sat);
    data_d.hi  = data_i.hi;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ hdl/rgbhsv_checker.sv @@
module rgbhsv_checker
  import rgbhsv_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input pix_out_t pix_o
);

  // a held result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pix_o))
  else $error("stalled result changed");

  // input holds off only when the output side is full and blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
  else $error("input stalled without output back-pressure");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pix_o.hue_deg < 9'd360)
  else $error("hue out of range");

  // black has no hue or saturation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pix_o.brightness == 8'd0 |->
      pix_o.hue_deg == 9'd0 && pix_o.saturation == 8'd0)
  else $error("black pixel with nonzero hue or saturation");

endmodule

bind rgb_to_hsv_pixel rgbhsv_checker u_checker (.*);
